### src/fcce_pkg.sv
// Shared types, constants and the control-store program of the FAT cluster chain engine.
// Used by the channel interfaces and by the top level; depends on nothing.
package fcce_pkg;

  // Field widths of the command and response words
  localparam int OP_W   = 2;
  localparam int CL_W   = 12;
  localparam int VAL_W  = 28;
  localparam int ST_W   = 2;
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 12;

  localparam int CLUSTERS_DEF = 4096;

  // Entry masks and end-of-chain marks
  localparam logic [VAL_W-1:0] MASK28 = 28'h0FF_FFFF | 28'hF00_0000;
  localparam logic [VAL_W-1:0] MASK16 = 28'h000_FFFF;
  localparam logic [VAL_W-1:0] EOC32  = 28'hFFF_FFF8;
  localparam logic [VAL_W-1:0] EOC16  = 28'h000_FFF8;

  // Register indexes and reset values
  localparam logic [CFG_IW-1:0] REG_FAT32_MODE  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_MAX_CLUSTER = 1'b1;
  localparam logic              FAT32_MODE_RST  = 1'b1;
  localparam logic [CL_W-1:0]   MAX_CLUSTER_RST = 12'd4095;

  typedef enum logic [OP_W-1:0] {OP_READ, OP_SET, OP_ALLOC, OP_FREE} op_t;

  typedef enum logic [ST_W-1:0] {ST_OK, ST_RANGE, ST_NO_FREE, ST_LOOP_CAP} status_t;

  // Control-store addresses
  typedef logic [3:0] upc_t;
  localparam upc_t U_IDLE  = 4'd0;
  localparam upc_t U_READ  = 4'd1;
  localparam upc_t U_SET   = 4'd2;
  localparam upc_t U_ALLOC = 4'd3;
  localparam upc_t U_FREE  = 4'd4;
  localparam upc_t U_SCAN  = 4'd5;
  localparam upc_t U_TEST  = 4'd6;
  localparam upc_t U_WALK  = 4'd7;
  localparam upc_t U_ZAP   = 4'd8;
  localparam upc_t U_CLEAR = 4'd9;

  typedef enum logic [2:0] {
    COND_ALWAYS, COND_ACCEPT, COND_OFF_TABLE, COND_INVALID,
    COND_PAST_TOP, COND_ZERO, COND_CAP, COND_CLEAR_END
  } cond_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD_IN, MEM_RD_CUR, MEM_WR_ZERO, MEM_WR_EOC, MEM_WR_NEW
  } mem_op_t;

  typedef enum logic [2:0] {CUR_HOLD, CUR_IN, CUR_TWO, CUR_INC, CUR_LINK} cur_op_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;

  typedef enum logic [1:0] {RES_NONE, RES_READ, RES_CUR, RES_ZERO} res_t;

  // One branch of a control word: datapath actions and the next address
  typedef struct packed {
    mem_op_t mem;
    cur_op_t cur;
    cnt_op_t cnt;
    res_t    res;
    status_t st;
    upc_t    nxt;
  } act_t;

  // Control word: a condition picks one of two branches
  typedef struct packed {
    cond_t cond;
    logic  dispatch;
    act_t  on_t;
    act_t  on_f;
  } uword_t;

  function automatic act_t mk(input mem_op_t m, input cur_op_t c, input cnt_op_t n,
                              input res_t r, input status_t s, input upc_t x);
    act_t a;
    a.mem = m;
    a.cur = c;
    a.cnt = n;
    a.res = r;
    a.st  = s;
    a.nxt = x;
    return a;
  endfunction

  // Control store
  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    w.cond     = COND_ALWAYS;
    w.dispatch = 1'b0;
    w.on_t     = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_IDLE);
    w.on_f     = w.on_t;
    case (addr)
      U_IDLE: begin
        // take a word, start its read, branch on the operation
        w.cond     = COND_ACCEPT;
        w.dispatch = 1'b1;
        w.on_t     = mk(MEM_RD_IN, CUR_IN, CNT_CLR, RES_NONE, ST_OK, U_IDLE);
        w.on_f     = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_IDLE);
      end
      U_READ: begin
        w.cond = COND_OFF_TABLE;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_RANGE, U_IDLE);
        w.on_f = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_READ, ST_OK, U_IDLE);
      end
      U_SET: begin
        w.cond = COND_INVALID;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_RANGE, U_IDLE);
        w.on_f = mk(MEM_WR_NEW, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_OK, U_IDLE);
      end
      U_ALLOC: begin
        w.cond = COND_ALWAYS;
        w.on_t = mk(MEM_NONE, CUR_TWO, CNT_HOLD, RES_NONE, ST_OK, U_SCAN);
        w.on_f = w.on_t;
      end
      U_FREE: begin
        w.cond = COND_INVALID;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_RANGE, U_IDLE);
        w.on_f = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_WALK);
      end
      U_SCAN: begin
        w.cond = COND_PAST_TOP;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_NO_FREE, U_IDLE);
        w.on_f = mk(MEM_RD_CUR, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_TEST);
      end
      U_TEST: begin
        w.cond = COND_ZERO;
        w.on_t = mk(MEM_WR_EOC, CUR_HOLD, CNT_HOLD, RES_CUR, ST_OK, U_IDLE);
        w.on_f = mk(MEM_NONE, CUR_INC, CNT_HOLD, RES_NONE, ST_OK, U_SCAN);
      end
      U_WALK: begin
        w.cond = COND_INVALID;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_OK, U_IDLE);
        w.on_f = mk(MEM_RD_CUR, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_ZAP);
      end
      U_ZAP: begin
        w.cond = COND_CAP;
        w.on_t = mk(MEM_NONE, CUR_HOLD, CNT_HOLD, RES_ZERO, ST_LOOP_CAP, U_IDLE);
        w.on_f = mk(MEM_WR_ZERO, CUR_LINK, CNT_INC, RES_NONE, ST_OK, U_WALK);
      end
      U_CLEAR: begin
        w.cond = COND_CLEAR_END;
        w.on_t = mk(MEM_WR_ZERO, CUR_HOLD, CNT_HOLD, RES_NONE, ST_OK, U_IDLE);
        w.on_f = mk(MEM_WR_ZERO, CUR_INC, CNT_HOLD, RES_NONE, ST_OK, U_CLEAR);
      end
      default: begin
        w.cond = COND_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

### src/fcce_cmd_if.sv
// Command channel of the FAT cluster chain engine: valid/ready with one command word.
// Depends on fcce_pkg for the field widths.
interface fcce_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fcce_pkg::OP_W-1:0]    op;
  logic [fcce_pkg::CL_W-1:0]    cluster;
  logic [fcce_pkg::VAL_W-1:0]   new_value;

  modport source (output valid, output op, output cluster, output new_value, input ready);
  modport sink   (input valid, input op, input cluster, input new_value, output ready);
endinterface

### src/fcce_rsp_if.sv
// Response channel of the FAT cluster chain engine: valid/ready with one result word.
// Depends on fcce_pkg for the field widths.
interface fcce_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fcce_pkg::VAL_W-1:0]   value;
  logic                         is_end;
  logic [fcce_pkg::ST_W-1:0]    status;

  modport source (output valid, output value, output is_end, output status, input ready);
  modport sink   (input valid, input value, input is_end, input status, output ready);
endinterface

### src/fat_cluster_chain_engine.sv
// FAT cluster chain engine: on-chip cluster table driven by a microcoded sequencer.
// Depends on fcce_pkg, fcce_cmd_if and fcce_rsp_if.
//
// Usage
//   cmd carries one command word (op, cluster, new_value); rsp returns exactly one result
//   word (value, is_end, status) per command, in order. The block works on one command at a
//   time: cmd.ready is high only while the sequencer sits at its idle step.
//   Configuration (cfg_we, cfg_index, cfg_data) is written at any edge with cfg_we high
//   and rst low; index 0 selects FAT32 mode, index 1 the highest valid cluster.
// Steps
//   Read and set: the idle step takes the command and starts its table read; the read or
//   set step then loads the result. Allocate: a scan step reads each entry from cluster 2
//   up and a test step checks it for zero, until a free one is found or the scan passes the
//   highest valid cluster. Free: after the range check, a walk step reads each link and a
//   zap step clears that entry. The single table port (one read and one write a cycle) and
//   the registered read data are why reads and their uses sit in separate steps.
// Reset
//   rst (synchronous) restores the register defaults and then sweeps zeros through the
//   table, one entry a cycle, from entry 0 to the last; no command is taken during the sweep.
// Stalls
//   A finished word waits in the output register. If it is not yet taken when the next
//   result is due, the sequencer holds that step, with no table access, until it is taken.
module fat_cluster_chain_engine #(
  parameter int CLUSTERS = fcce_pkg::CLUSTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fcce_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [fcce_pkg::CFG_DW-1:0]   cfg_data,
  fcce_cmd_if.sink                      cmd,
  fcce_rsp_if.source                    rsp
);
  import fcce_pkg::*;

  localparam int AW = $clog2(CLUSTERS);
  localparam int IW = (AW > CL_W) ? AW : CL_W;
  localparam int SW = $clog2(CLUSTERS + 1);
  localparam logic [VAL_W-1:0] TABLE_END  = VAL_W'(CLUSTERS);
  localparam logic [VAL_W-1:0] TABLE_LAST = VAL_W'(CLUSTERS - 1);
  localparam logic [SW-1:0]    STEP_CAP   = SW'(CLUSTERS);
  localparam logic [VAL_W-1:0] FIRST_CL   = VAL_W'(2);

  // Configuration registers
  logic            fat32_mode;
  logic [CL_W-1:0] max_cluster;

  // Sequencer and datapath registers
  upc_t            upc;
  logic [VAL_W-1:0] cur;
  logic [SW-1:0]   steps;
  logic [VAL_W-1:0] nv;
  logic [VAL_W-1:0] rd_data;
  logic            rsp_valid;
  logic [VAL_W-1:0] rsp_value;
  logic            rsp_is_end;
  logic [ST_W-1:0] rsp_status;

  logic [VAL_W-1:0] mem [CLUSTERS];

  // Next values and control
  upc_t             upc_next;
  logic [VAL_W-1:0] cur_next;
  logic [SW-1:0]    steps_next;
  uword_t           w;
  act_t             a;
  logic             hit;
  logic             adv;
  logic             load_out;
  logic [VAL_W-1:0] mask;
  logic [CL_W-1:0]  top;
  logic             cur_valid;
  logic [VAL_W-1:0] rd_view;
  logic             rd_end;
  logic [IW-1:0]    in_cl;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [VAL_W-1:0] out_value;

  // Mode view and valid range
  always_comb begin
    mask      = fat32_mode ? MASK28 : MASK16;
    top       = (VAL_W'(max_cluster) >= TABLE_END) ? TABLE_LAST[CL_W-1:0] : max_cluster;
    cur_valid = (cur >= FIRST_CL) && (cur <= VAL_W'(top));
    rd_view   = rd_data & mask;
    rd_end    = fat32_mode ? (rd_view >= EOC32) : (rd_view >= EOC16);
    in_cl     = IW'(cmd.cluster);
  end

  // Fetch the control word and resolve its condition
  always_comb begin
    w = ucode(upc);
    case (w.cond)
      COND_ALWAYS:    hit = 1'b1;
      COND_ACCEPT:    hit = cmd.valid;
      COND_OFF_TABLE: hit = (cur >= TABLE_END);
      COND_INVALID:   hit = !cur_valid;
      COND_PAST_TOP:  hit = (cur > VAL_W'(top));
      COND_ZERO:      hit = (rd_view == '0);
      COND_CAP:       hit = (steps == STEP_CAP);
      COND_CLEAR_END: hit = (cur == TABLE_LAST);
      default:        hit = 1'b0;
    endcase
    a        = hit ? w.on_t : w.on_f;
    // hold a step that loads a result while a finished word still waits
    adv      = !((a.res != RES_NONE) && rsp_valid && !rsp.ready);
    load_out = adv && (a.res != RES_NONE);
  end

  // Next step address
  always_comb begin
    upc_next = upc;
    if (adv) begin
      if (hit && w.dispatch) begin
        case (op_t'(cmd.op))
          OP_READ:  upc_next = U_READ;
          OP_SET:   upc_next = U_SET;
          OP_ALLOC: upc_next = U_ALLOC;
          OP_FREE:  upc_next = U_FREE;
          default:  upc_next = U_IDLE;
        endcase
      end else begin
        upc_next = a.nxt;
      end
    end
  end

  // Datapath next values
  always_comb begin
    case (a.cur)
      CUR_IN:   cur_next = VAL_W'(cmd.cluster);
      CUR_TWO:  cur_next = FIRST_CL;
      CUR_INC:  cur_next = cur + VAL_W'(1);
      CUR_LINK: cur_next = rd_view;
      default:  cur_next = cur;
    endcase
    case (a.cnt)
      CNT_CLR: steps_next = '0;
      CNT_INC: steps_next = steps + SW'(1);
      default: steps_next = steps;
    endcase
    case (a.res)
      RES_READ: out_value = rd_view;
      RES_CUR:  out_value = cur;
      default:  out_value = '0;
    endcase
  end

  // Table port control
  always_comb begin
    mem_we    = adv && ((a.mem == MEM_WR_ZERO) || (a.mem == MEM_WR_EOC) ||
                        (a.mem == MEM_WR_NEW));
    mem_re    = adv && ((a.mem == MEM_RD_IN) || (a.mem == MEM_RD_CUR));
    mem_waddr = cur[AW-1:0];
    mem_raddr = (a.mem == MEM_RD_IN) ? in_cl[AW-1:0] : cur[AW-1:0];
    case (a.mem)
      MEM_WR_EOC: mem_wdata = fat32_mode ? EOC32 : EOC16;
      MEM_WR_NEW: mem_wdata = nv & mask;
      default:    mem_wdata = '0;
    endcase
  end

  // Cluster table: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fat32_mode  <= FAT32_MODE_RST;
      max_cluster <= MAX_CLUSTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAT32_MODE:  fat32_mode  <= cfg_data[0];
        REG_MAX_CLUSTER: max_cluster <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state, datapath and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_CLEAR;
      cur       <= '0;
      steps     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      upc   <= upc_next;
      steps <= adv ? steps_next : steps;
      cur   <= adv ? cur_next : cur;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    // latch the value to write with the command
    if (adv && (a.cur == CUR_IN)) begin
      nv <= cmd.new_value;
    end
    if (load_out) begin
      rsp_value  <= out_value;
      rsp_is_end <= (a.res == RES_READ) && rd_end;
      rsp_status <= a.st;
    end
  end

  assign cmd.ready  = (upc == U_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.value  = rsp_value;
  assign rsp.is_end = rsp_is_end;
  assign rsp.status = rsp_status;

  // A result never overwrites a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!rsp_valid || rsp.ready))
    else $error("result loaded over a pending word");

  // Table writes stay inside the table
  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (VAL_W'(mem_waddr) < TABLE_END))
    else $error("table write beyond last entry");

  // An accepted command always leaves the idle step
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> (upc != U_IDLE))
    else $error("accepted command not started");

  // The walk counter never passes its cap
  a_step_cap: assert property (@(posedge clk) disable iff (rst)
    steps <= STEP_CAP)
    else $error("walk counter past cap");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for fat_cluster_chain_engine: a directed table, then biased random
// commands over several mode and volume-size settings, checked against an in-bench table.
// Depends on fcce_pkg, fcce_cmd_if, fcce_rsp_if and the engine itself.
module testbench;
  import fcce_pkg::*;

  localparam int NCL             = CLUSTERS_DEF;
  localparam int N_DIR           = 25;
  localparam int N_PHASES        = 7;
  localparam int ITEMS_PER_PHASE = 122;
  // Longest quiet stretch: the reset sweep, a full allocation scan or a free of a
  // chain through every cluster, plus a receiver stall.
  localparam int STALL_LIMIT     = 40000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_end;
    status_t          status;
  } fat_word_t;

  typedef struct {
    op_t              op;
    logic [CL_W-1:0]  cl;
    logic [VAL_W-1:0] nv;
    bit               typed;
    fat_word_t        want;
  } dir_row_t;

  localparam fat_word_t OK_ZERO    = '{'0, 1'b0, ST_OK};
  localparam fat_word_t RANGE_ZERO = '{'0, 1'b0, ST_RANGE};

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  fcce_cmd_if cmd_ch ();
  fcce_rsp_if rsp_ch ();

  fat_cluster_chain_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the cluster table and its settings
  logic [VAL_W-1:0] shadow_fat [NCL];
  bit               shadow_fat32;
  logic [CL_W-1:0]  shadow_max;

  fat_word_t owed_words [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  int        sent_count     = 0;
  bit        cmd_held       = 1'b0;
  bit        cmd_burst      = 1'b0;
  bit        rsp_burst      = 1'b0;

  // Directed commands after reset: FAT32 mode, whole volume
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_READ,  12'd0,    28'd0,         1'b1, OK_ZERO},
    '{OP_READ,  12'd4095, 28'd0,         1'b1, OK_ZERO},
    '{OP_SET,   12'd2,    28'hFFFFFFF,   1'b1, OK_ZERO},
    '{OP_READ,  12'd2,    28'd0,         1'b1, '{28'hFFFFFFF, 1'b1, ST_OK}},
    '{OP_SET,   12'd0,    28'h123,       1'b1, RANGE_ZERO},
    '{OP_SET,   12'd1,    28'hFFFFFFF,   1'b1, RANGE_ZERO},
    '{OP_READ,  12'd1,    28'd0,         1'b1, OK_ZERO},
    '{OP_SET,   12'd4095, 28'hFFFFFF7,   1'b1, OK_ZERO},
    '{OP_READ,  12'd4095, 28'd0,         1'b1, '{28'hFFFFFF7, 1'b0, ST_OK}},
    '{OP_SET,   12'd3,    28'hFFFFFF8,   1'b1, OK_ZERO},
    '{OP_READ,  12'd3,    28'd0,         1'b1, '{28'hFFFFFF8, 1'b1, ST_OK}},
    '{OP_ALLOC, 12'd0,    28'd0,         1'b0, OK_ZERO},
    '{OP_SET,   12'd4,    28'd5,         1'b0, OK_ZERO},
    '{OP_ALLOC, 12'd4095, 28'hFFFFFFF,   1'b0, OK_ZERO},
    '{OP_READ,  12'd5,    28'd0,         1'b0, OK_ZERO},
    '{OP_FREE,  12'd4,    28'd0,         1'b0, OK_ZERO},
    '{OP_READ,  12'd4,    28'd0,         1'b0, OK_ZERO},
    '{OP_FREE,  12'd0,    28'd0,         1'b1, RANGE_ZERO},
    '{OP_FREE,  12'd1,    28'd0,         1'b1, RANGE_ZERO},
    '{OP_FREE,  12'd2,    28'd0,         1'b0, OK_ZERO},
    '{OP_FREE,  12'd4095, 28'd0,         1'b0, OK_ZERO},
    '{OP_SET,   12'd10,   28'd11,        1'b0, OK_ZERO},
    '{OP_SET,   12'd11,   28'd10,        1'b0, OK_ZERO},
    '{OP_FREE,  12'd10,   28'd0,         1'b0, OK_ZERO},
    '{OP_ALLOC, 12'd0,    28'd0,         1'b0, OK_ZERO}
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Entry as seen through the current mode
  function automatic logic [VAL_W-1:0] view(input logic [VAL_W-1:0] v);
    return shadow_fat32 ? (v & MASK28) : (v & MASK16);
  endfunction

  function automatic bit chain_end(input logic [VAL_W-1:0] v);
    return shadow_fat32 ? (v >= EOC32) : (v >= EOC16);
  endfunction

  function automatic bit in_volume(input logic [VAL_W-1:0] c);
    return (c >= 2) && (c <= shadow_max);
  endfunction

  // Apply one command to the shadow table and return the word it yields
  function automatic fat_word_t run_fat_cmd(input op_t op, input logic [CL_W-1:0] cl,
                                            input logic [VAL_W-1:0] nv);
    fat_word_t        w;
    logic [VAL_W-1:0] cur;
    logic [VAL_W-1:0] link;
    int               steps;
    int               k;
    w = OK_ZERO;
    case (op)
      OP_READ: begin
        w.value  = view(shadow_fat[cl]);
        w.is_end = chain_end(w.value);
      end
      OP_SET: begin
        if (in_volume(VAL_W'(cl))) shadow_fat[cl] = view(nv);
        else w.status = ST_RANGE;
      end
      OP_ALLOC: begin
        // lowest free cluster wins and becomes end of chain
        w.status = ST_NO_FREE;
        for (k = 2; k <= shadow_max; k++) begin
          if (view(shadow_fat[k]) == '0) begin
            shadow_fat[k] = shadow_fat32 ? EOC32 : EOC16;
            w.value       = VAL_W'(k);
            w.status      = ST_OK;
            break;
          end
        end
      end
      default: begin
        if (!in_volume(VAL_W'(cl))) begin
          w.status = ST_RANGE;
        end else begin
          // follow links, zeroing each, until a link leaves the volume or the step cap is hit
          cur   = VAL_W'(cl);
          steps = 0;
          while (in_volume(cur) && !chain_end(cur)) begin
            if (steps >= NCL) begin
              w.status = ST_LOOP_CAP;
              break;
            end
            link                     = view(shadow_fat[cur[CL_W-1:0]]);
            shadow_fat[cur[CL_W-1:0]] = '0;
            steps++;
            cur = link;
          end
        end
      end
    endcase
    return w;
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [CL_W-1:0] pick_cluster();
    case ($urandom_range(0, 5))
      0:       return CL_W'($urandom_range(0, 1));
      1:       return shadow_max + CL_W'($urandom_range(0, 1));
      2:       return 12'hFFF;
      3, 4:    return CL_W'($urandom_range(2, shadow_max));
      default: return CL_W'($urandom_range(0, NCL - 1));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return VAL_W'($urandom_range(2, shadow_max));
      2:       return VAL_W'($urandom_range(16'hFFF0, 16'hFFFF));
      3:       return VAL_W'($urandom_range(28'hFFFFFF0, 28'hFFFFFFF));
      default: return VAL_W'($urandom) & MASK28;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one command word, hold it until taken, then log what it owes
  task automatic issue_cmd(input op_t op, input logic [CL_W-1:0] cl,
                           input logic [VAL_W-1:0] nv, input bit typed,
                           input fat_word_t want, output fat_word_t got);
    int        gap;
    fat_word_t pred;
    gap = draw_gap(cmd_burst);
    if (gap > 0) begin
      if (cmd_held) cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= op;
    cmd_ch.cluster   <= cl;
    cmd_ch.new_value <= nv;
    cmd_held = 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pred = run_fat_cmd(op, cl, nv);
    owed_words.push_back(typed ? want : pred);
    got = pred;
    sent_count++;
  endtask

  task automatic pred_cmd(input op_t op, input logic [CL_W-1:0] cl,
                          input logic [VAL_W-1:0] nv, output fat_word_t got);
    issue_cmd(op, cl, nv, 1'b0, OK_ZERO, got);
  endtask

  // Drop valid and let every owed word come back
  task automatic drain_results();
    if (cmd_held) cmd_ch.valid <= 1'b0;
    cmd_held = 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input bit fat32, input logic [CL_W-1:0] top);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FAT32_MODE;
    cfg_data  <= CFG_DW'(fat32);
    @(posedge clk);
    cfg_index <= REG_MAX_CLUSTER;
    cfg_data  <= top;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_fat32 = fat32;
    shadow_max   = top;
  endtask

  // Allocate a few clusters, link them, end or close the chain, read one, often free it
  task automatic build_chain();
    logic [CL_W-1:0] links [$];
    fat_word_t       r;
    int              n;
    int              i;
    n = $urandom_range(1, 5);
    repeat (n) begin
      pred_cmd(OP_ALLOC, pick_cluster(), pick_value(), r);
      if (r.status == ST_OK) links.push_back(r.value[CL_W-1:0]);
    end
    for (i = 0; i + 1 < links.size(); i++)
      pred_cmd(OP_SET, links[i], VAL_W'(links[i+1]), r);
    if (links.size() != 0) begin
      case ($urandom_range(0, 3))
        0:       pred_cmd(OP_SET, links[links.size()-1], pick_value(), r);
        1:       pred_cmd(OP_SET, links[links.size()-1], VAL_W'(links[0]), r);
        default: ;
      endcase
      pred_cmd(OP_READ, links[$urandom_range(0, links.size() - 1)], pick_value(), r);
      if ($urandom_range(0, 3) != 0) pred_cmd(OP_FREE, links[0], pick_value(), r);
    end
  endtask

  // Check each returned word against the oldest owed one
  initial begin
    fat_word_t want;
    int        gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rsp_burst);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (owed_words.size() == 0) begin
        flag_mismatch("word with none owed", rsp_ch.value, '0);
      end else begin
        want = owed_words.pop_front();
        if (rsp_ch.value !== want.value) flag_mismatch("value", rsp_ch.value, want.value);
        if (rsp_ch.is_end !== want.is_end)
          flag_mismatch("is_end", VAL_W'(rsp_ch.is_end), VAL_W'(want.is_end));
        if (rsp_ch.status !== want.status)
          flag_mismatch("status", VAL_W'(rsp_ch.status), VAL_W'(want.status));
      end
      if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fat_word_t       r;
    int              i;
    int              p;
    int              phase_end;
    bit              fat32;
    logic [CL_W-1:0] top;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.op        <= '0;
    cmd_ch.cluster   <= '0;
    cmd_ch.new_value <= '0;
    for (i = 0; i < NCL; i++) shadow_fat[i] = '0;
    shadow_fat32 = FAT32_MODE_RST;
    shadow_max   = MAX_CLUSTER_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (i = 0; i < N_DIR; i++)
      issue_cmd(dir_rows[i].op, dir_rows[i].cl, dir_rows[i].nv, dir_rows[i].typed,
                dir_rows[i].want, r);

    // Random phases: reset settings, FAT16, tiny volumes, mid sizes, back to full
    for (p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        fat32 = (p == 2) || (p >= 5);
        case (p)
          2, 3:    top = 12'd3;
          4, 5:    top = CL_W'($urandom_range(4, 600));
          default: top = 12'd4095;
        endcase
        set_config(fat32, top);
      end
      cmd_burst = (p % 3 == 2);
      phase_end = sent_count + ITEMS_PER_PHASE;
      while (sent_count < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3:
            build_chain();
          4, 5, 6, 7:
            pred_cmd(op_t'($urandom_range(0, 3)), pick_cluster(), pick_value(), r);
          default:
            pred_cmd(op_t'($urandom_range(0, 3)), CL_W'($urandom_range(0, NCL - 1)),
                     VAL_W'($urandom) & MASK28, r);
        endcase
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
